// File: design/bemap_pkg.sv
// ----------------------------------------------------------------------------
// bemap_pkg
// Shared types and constants for the button edge / autofire mapper.
// ----------------------------------------------------------------------------
package bemap_pkg;

  localparam int BUTTON_COUNT_DEF = 22;
  localparam int MAX_BUTTONS      = 32;
  localparam int MASK_W           = 22;
  localparam int BIDX_W           = 5;
  localparam int TIME_W           = 32;
  localparam int INTERVAL_W       = 16;
  localparam int CFG_IDX_W        = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(90);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHORD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MACRO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAPID    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

  // request types
  localparam logic REQ_SAMPLE      = 1'b0;
  localparam logic REQ_RELEASE_ALL = 1'b1;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_TAP     = 2'd2,
    EV_MACRO   = 2'd3
  } ev_code_t;

  typedef struct packed {
    logic              req_type;
    logic [MASK_W-1:0] button_levels;
    logic              sample_valid;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [BIDX_W-1:0] button_index;
    ev_code_t          event_code;
    logic              last_event;
  } out_item_t;

endpackage

// File: design/button_edge_autofire_mapper_top.sv
// ----------------------------------------------------------------------------
// button_edge_autofire_mapper_top
// Walks the buttons of each sample against the previous levels and a
// per-button last fire time kept in a synchronous memory.
// ----------------------------------------------------------------------------
// flow: invalid or seeding samples finish in the accept cycle; sample and
//   release-all requests walk the buttons through the start, walk and flush
//   states; flush offers the last event, if any, once the output takes it
// throughput: one item at a time, one button per cycle set by the single read and
//   write port of the fire time memory, unless an output stall holds the walk
// reset: synchronous active low; masks clear, interval returns to 90, levels,
//   seeded flag and fire time valid bits clear; no clearing pass is needed
module button_edge_autofire_mapper_top #(
  parameter int BUTTON_COUNT = bemap_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bemap_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bemap_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [bemap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bemap_pkg::MASK_W-1:0]        cfg_wdata
);

  localparam int IDXW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(BUTTON_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  // configuration
  logic [bemap_pkg::MASK_W-1:0]     chord_r, macro_r, rapid_r;
  logic [bemap_pkg::INTERVAL_W-1:0] interval_r;

  // block state
  state_t                      state_r, state_nxt;
  logic [BUTTON_COUNT-1:0]     prev_r, prev_nxt;
  logic                        seeded_r, seeded_nxt;
  logic [BUTTON_COUNT-1:0]     fire_vld_r, fire_vld_nxt;
  logic [IDXW-1:0]             idx_r, idx_nxt;

  // latched item
  logic                        req_r;
  logic [BUTTON_COUNT-1:0]     levels_r;
  logic [bemap_pkg::TIME_W-1:0] now_r;

  // pending event, held until the next one shows whether it is the last
  logic                        pend_vld_r, pend_vld_nxt;
  logic [IDXW-1:0]             pend_idx_r;
  bemap_pkg::ev_code_t         pend_code_r;

  logic                        out_valid_r, out_valid_nxt;
  bemap_pkg::out_item_t        out_data_r;

  // fire time memory
  logic [bemap_pkg::TIME_W-1:0] fire_mem [BUTTON_COUNT];
  logic [bemap_pkg::TIME_W-1:0] mem_rdata_r;
  logic                         mem_re, mem_we;
  logic [IDXW-1:0]              mem_raddr;

  // widened views
  logic [bemap_pkg::MAX_BUTTONS-1:0] lev_ext, chord_ext, macro_ext, rapid_ext;
  logic [BUTTON_COUNT-1:0]           lev_n, chord_n, macro_n, rapid_n;

  // per-button evaluation
  logic                         accept;
  logic                         can_push, push, push_last, advance;
  logic                         ev_hit, fire_wr, prev_bit;
  bemap_pkg::ev_code_t          ev_code;
  logic                         b_chord, b_macro, b_rapid, b_pressed, b_was;
  logic                         rising, elapsed, rdy;
  logic [bemap_pkg::TIME_W-1:0] lft;

  assign lev_ext   = bemap_pkg::MAX_BUTTONS'(in_data.button_levels);
  assign chord_ext = bemap_pkg::MAX_BUTTONS'(chord_r);
  assign macro_ext = bemap_pkg::MAX_BUTTONS'(macro_r);
  assign rapid_ext = bemap_pkg::MAX_BUTTONS'(rapid_r);
  assign lev_n     = lev_ext[BUTTON_COUNT-1:0];
  assign chord_n   = chord_ext[BUTTON_COUNT-1:0];
  assign macro_n   = macro_ext[BUTTON_COUNT-1:0];
  assign rapid_n   = rapid_ext[BUTTON_COUNT-1:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_push  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    b_chord   = chord_n[idx_r];
    b_macro   = macro_n[idx_r];
    b_rapid   = rapid_n[idx_r];
    b_pressed = levels_r[idx_r];
    b_was     = prev_r[idx_r];
    rising    = b_pressed && !b_was;
    lft       = fire_vld_r[idx_r] ? mem_rdata_r : '0;
    elapsed   = (now_r - lft) >= bemap_pkg::TIME_W'(interval_r);
    rdy       = b_rapid && (rising || elapsed);
    ev_hit    = 1'b0;
    ev_code   = bemap_pkg::EV_PRESS;
    fire_wr   = 1'b0;
    prev_bit  = b_was;
    if (req_r == bemap_pkg::REQ_RELEASE_ALL) begin
      if (b_was && b_chord && !b_rapid) begin
        ev_hit  = 1'b1;
        ev_code = bemap_pkg::EV_RELEASE;
      end
    end else if (b_chord || b_macro) begin
      prev_bit = b_pressed;
      if (b_pressed) begin
        if (b_chord) begin
          if (rdy) begin
            ev_hit  = 1'b1;
            ev_code = bemap_pkg::EV_TAP;
            fire_wr = 1'b1;
          end else if (rising) begin
            ev_hit  = 1'b1;
            ev_code = bemap_pkg::EV_PRESS;
          end
        end else if (rising || rdy) begin
          ev_hit  = 1'b1;
          ev_code = bemap_pkg::EV_MACRO;
          fire_wr = 1'b1;
        end
      end else if (b_was && b_chord && !b_rapid) begin
        ev_hit  = 1'b1;
        ev_code = bemap_pkg::EV_RELEASE;
      end
    end
  end

  // walk and flush control
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    prev_nxt     = prev_r;
    seeded_nxt   = seeded_r;
    fire_vld_nxt = fire_vld_r;
    pend_vld_nxt = pend_vld_r;
    push         = 1'b0;
    push_last    = 1'b0;
    advance      = 1'b0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_raddr    = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == bemap_pkg::REQ_RELEASE_ALL) begin
            state_nxt = ST_START;
          end else if (in_data.sample_valid) begin
            if (!seeded_r) begin
              prev_nxt   = lev_n;
              seeded_nxt = 1'b1;
            end else begin
              state_nxt = ST_START;
            end
          end
        end
      end
      ST_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        idx_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // a new event pushes the older pending one out
        advance = !(ev_hit && pend_vld_r) || can_push;
        if (advance) begin
          push     = ev_hit && pend_vld_r;
          mem_we   = fire_wr;
          prev_nxt[idx_r] = prev_bit;
          if (fire_wr) begin
            fire_vld_nxt[idx_r] = 1'b1;
          end
          if (ev_hit) begin
            pend_vld_nxt = 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r || can_push) begin
          push         = pend_vld_r;
          push_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
          if (req_r == bemap_pkg::REQ_RELEASE_ALL) begin
            prev_nxt     = '0;
            seeded_nxt   = 1'b0;
            fire_vld_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      seeded_r    <= 1'b0;
      fire_vld_r  <= '0;
      idx_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      chord_r     <= '0;
      macro_r     <= '0;
      rapid_r     <= '0;
      interval_r  <= bemap_pkg::INTERVAL_RST;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      seeded_r    <= seeded_nxt;
      fire_vld_r  <= fire_vld_nxt;
      idx_r       <= idx_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bemap_pkg::CFG_CHORD:    chord_r    <= cfg_wdata;
          bemap_pkg::CFG_MACRO:    macro_r    <= cfg_wdata;
          bemap_pkg::CFG_RAPID:    rapid_r    <= cfg_wdata;
          bemap_pkg::CFG_INTERVAL: interval_r <= cfg_wdata[bemap_pkg::INTERVAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_data.req_type;
      levels_r <= lev_n;
      now_r    <= in_data.now_ms;
    end
    if (state_r == ST_WALK && advance && ev_hit) begin
      pend_idx_r  <= idx_r;
      pend_code_r <= ev_code;
    end
    if (push) begin
      out_data_r.button_index <= bemap_pkg::BIDX_W'(pend_idx_r);
      out_data_r.event_code   <= pend_code_r;
      out_data_r.last_event   <= push_last;
    end
  end

  // fire time memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fire_mem[idx_r] <= now_r;
    end
    if (mem_re) begin
      mem_rdata_r <= fire_mem[mem_raddr];
    end
  end

endmodule

// File: design/bemap_checker.sv
// ----------------------------------------------------------------------------
// bemap_checker
// Port-level checks for the button edge / autofire mapper.
// ----------------------------------------------------------------------------
module bemap_checker #(
  parameter int BUTTON_COUNT = bemap_pkg::BUTTON_COUNT_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input bemap_pkg::out_item_t out_data
);

  // after reset the block is empty and takes input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.button_index < bemap_pkg::BIDX_W'(BUTTON_COUNT)))
    else $error("button index out of range");

  // more events of the same item follow, so no new item is taken
  a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_event) |-> !in_ready)
    else $error("input taken while an item still has events to deliver");

endmodule

bind button_edge_autofire_mapper_top bemap_checker #(
  .BUTTON_COUNT(BUTTON_COUNT)
) u_bemap_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
